@@ rtl/stli_pkg.sv @@
// Shared constants, codes and request types for the sorted table interpolation core.
// No dependencies; compile first.
package stli_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int MODE_W    = 2;
  localparam int KEY_W     = 16;
  localparam int VAL_W     = 32;
  localparam int STATUS_W  = 3;
  localparam int HELD_W    = 7;

  localparam int DK_W   = KEY_W + 1;
  localparam int DF_W   = VAL_W + 1;
  localparam int PROD_W = DK_W + DF_W;
  localparam int DEN_W  = KEY_W;
  localparam int SUM_W  = VAL_W + 2;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXACT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INTERP  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

  typedef struct packed {
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic signed [KEY_W-1:0] wkey;
    logic signed [VAL_W-1:0] wval;
    logic [IDX_W-1:0]        raddr;
  } mem_req_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DEN_W-1:0]  divisor;
  } div_req_t;

endpackage

@@ rtl/stli_if.sv @@
// Request and result channel interfaces, valid/ready handshake with payload.
// Depends on stli_pkg.
interface stli_in_if;
  logic                             valid;
  logic                             ready;
  logic [stli_pkg::MODE_W-1:0]      mode;
  logic signed [stli_pkg::KEY_W-1:0] key;
  logic signed [stli_pkg::VAL_W-1:0] entry_value;

  modport source (output valid, output mode, output key, output entry_value, input ready);
  modport sink   (input valid, input mode, input key, input entry_value, output ready);
endinterface

interface stli_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [stli_pkg::VAL_W-1:0] result_value;
  logic [stli_pkg::STATUS_W-1:0]     status;
  logic [stli_pkg::HELD_W-1:0]       entries_held;

  modport source (output valid, output result_value, output status, output entries_held,
                  input ready);
  modport sink   (input valid, input result_value, input status, input entries_held,
                  output ready);
endinterface

@@ rtl/stli_table.sv @@
// Key and value memories: one write port, one read port with registered data.
// Depends on stli_pkg.
module stli_table (
  input  logic                              clk,
  input  stli_pkg::mem_req_t                mem_req,
  output logic signed [stli_pkg::KEY_W-1:0] rd_key,
  output logic signed [stli_pkg::VAL_W-1:0] rd_val
);

  logic signed [stli_pkg::KEY_W-1:0] key_mem [stli_pkg::TABLE_DEPTH];
  logic signed [stli_pkg::VAL_W-1:0] val_mem [stli_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      key_mem[mem_req.waddr] <= mem_req.wkey;
      val_mem[mem_req.waddr] <= mem_req.wval;
    end
    rd_key <= key_mem[mem_req.raddr];
    rd_val <= val_mem[mem_req.raddr];
  end

endmodule

@@ rtl/stli_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on stli_pkg.
module stli_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  stli_pkg::div_req_t              div_req,
  output logic                            done,
  output logic [stli_pkg::PROD_W-1:0]     quotient
);

  localparam int STEP_W = $clog2(stli_pkg::PROD_W);

  logic                          busy_r;
  logic                          done_r;
  logic [STEP_W-1:0]             step_r;
  logic [stli_pkg::PROD_W-1:0]   quo_r;
  logic [stli_pkg::DEN_W-1:0]    rem_r;
  logic [stli_pkg::DEN_W-1:0]    den_r;
  logic [stli_pkg::DEN_W:0]      shifted;
  logic [stli_pkg::DEN_W+1:0]    trial;

  assign shifted = {rem_r, quo_r[stli_pkg::PROD_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (div_req.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(stli_pkg::PROD_W - 1);
        quo_r  <= div_req.dividend;
        rem_r  <= '0;
        den_r  <= div_req.divisor;
      end else if (busy_r) begin
        if (trial[stli_pkg::DEN_W+1]) begin
          rem_r <= shifted[stli_pkg::DEN_W-1:0];
          quo_r <= {quo_r[stli_pkg::PROD_W-2:0], 1'b0};
        end else begin
          rem_r <= trial[stli_pkg::DEN_W-1:0];
          quo_r <= {quo_r[stli_pkg::PROD_W-2:0], 1'b1};
        end
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/sorted_table_linear_interpolation_core.sv @@
// Top level: sequencer, table memories and shared divider of the interpolation core.
// Depends on stli_pkg, stli_if, stli_table and stli_div.
//
//   channel   direction  handshake      payload
//   in_req    in         valid/ready    mode, key, entry_value
//   out_rsp   out        valid/ready    result_value, status, entries_held
//
// Clear, unused mode and load into a full table go straight to the result. Load moves
// larger entries up one slot at a time until the walk stops. Query scans the entries in
// order through the single table read port; an interpolation then multiplies, starts the
// divider, waits for it and finishes. One item at a time.
// Reset empties the table at once; no clearing pass. A stalled result waits in the
// output register while the next request is taken; that one holds until it frees.
module sorted_table_linear_interpolation_core (
  input logic         clk,
  input logic         rst_n,
  stli_in_if.sink     in_req,
  stli_out_if.source  out_rsp
);

  typedef enum logic [3:0] {
    S_IDLE, S_LD_RD, S_LD_CMP, S_Q_RD, S_Q_CMP, S_MUL, S_DIV_GO, S_DIV_WAIT, S_DONE
  } state_t;

  state_t                               state_r, state_nxt;
  logic [stli_pkg::CNT_W-1:0]           count_r, count_nxt;
  logic [stli_pkg::CNT_W-1:0]           pos_r, pos_nxt;
  logic signed [stli_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic signed [stli_pkg::VAL_W-1:0]    val_r, val_nxt;
  logic signed [stli_pkg::KEY_W-1:0]    prev_key_r, prev_key_nxt;
  logic signed [stli_pkg::VAL_W-1:0]    prev_val_r, prev_val_nxt;
  logic signed [stli_pkg::DK_W-1:0]     diff_k_r, diff_k_nxt;
  logic signed [stli_pkg::DF_W-1:0]     diff_f_r, diff_f_nxt;
  logic [stli_pkg::DEN_W-1:0]           den_r, den_nxt;
  logic signed [stli_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic                                 neg_r, neg_nxt;
  logic signed [stli_pkg::VAL_W-1:0]    res_value_r, res_value_nxt;
  logic [stli_pkg::STATUS_W-1:0]        res_status_r, res_status_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic signed [stli_pkg::VAL_W-1:0]    out_value_r, out_value_nxt;
  logic [stli_pkg::STATUS_W-1:0]        out_status_r, out_status_nxt;
  logic [stli_pkg::HELD_W-1:0]          out_held_r, out_held_nxt;

  stli_pkg::mem_req_t                   mem_req;
  stli_pkg::div_req_t                   div_req;
  logic signed [stli_pkg::KEY_W-1:0]    rd_key;
  logic signed [stli_pkg::VAL_W-1:0]    rd_val;
  logic                                 div_done;
  logic [stli_pkg::PROD_W-1:0]          quotient;

  logic                                 accept;
  logic [stli_pkg::KEY_W:0]             den_wide;
  logic [stli_pkg::SUM_W-1:0]           q_mag;
  logic [stli_pkg::SUM_W-1:0]           q_signed;
  logic [stli_pkg::SUM_W-1:0]           sum;
  logic signed [stli_pkg::VAL_W-1:0]    sum_sat;

  stli_table u_table (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_key  (rd_key),
    .rd_val  (rd_val)
  );

  stli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .div_req  (div_req),
    .done     (div_done),
    .quotient (quotient)
  );

  assign in_req.ready         = (state_r == S_IDLE);
  assign accept               = in_req.valid && in_req.ready;
  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.result_value = out_value_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.entries_held = out_held_r;

  assign den_wide = {rd_key[stli_pkg::KEY_W-1], rd_key}
                  - {prev_key_r[stli_pkg::KEY_W-1], prev_key_r};
  assign q_mag    = quotient[stli_pkg::SUM_W-1:0];
  assign q_signed = neg_r ? (~q_mag + 1'b1) : q_mag;
  assign sum      = {{2{prev_val_r[stli_pkg::VAL_W-1]}}, prev_val_r} + q_signed;

  always_comb begin
    priority if (!sum[stli_pkg::SUM_W-1]
                 && (sum[stli_pkg::SUM_W-2:stli_pkg::VAL_W-1] != 2'b00)) begin
      sum_sat = {1'b0, {(stli_pkg::VAL_W-1){1'b1}}};
    end else if (sum[stli_pkg::SUM_W-1]
                 && (sum[stli_pkg::SUM_W-2:stli_pkg::VAL_W-1] != 2'b11)) begin
      sum_sat = {1'b1, {(stli_pkg::VAL_W-1){1'b0}}};
    end else begin
      sum_sat = sum[stli_pkg::VAL_W-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    prev_key_nxt   = prev_key_r;
    prev_val_nxt   = prev_val_r;
    diff_k_nxt     = diff_k_r;
    diff_f_nxt     = diff_f_r;
    den_nxt        = den_r;
    prod_nxt       = prod_r;
    neg_nxt        = neg_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_held_nxt   = out_held_r;

    mem_req.we     = 1'b0;
    mem_req.waddr  = pos_r[stli_pkg::IDX_W-1:0];
    mem_req.wkey   = key_r;
    mem_req.wval   = val_r;
    mem_req.raddr  = pos_r[stli_pkg::IDX_W-1:0];

    div_req.start    = 1'b0;
    div_req.dividend = prod_r[stli_pkg::PROD_W-1] ? (~prod_r + 1'b1) : prod_r;
    div_req.divisor  = den_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt       = in_req.key;
          val_nxt       = in_req.entry_value;
          res_value_nxt = '0;
          pos_nxt       = '0;
          unique case (in_req.mode)
            stli_pkg::MODE_CLEAR: begin
              count_nxt      = '0;
              res_status_nxt = stli_pkg::ST_CLEARED;
              state_nxt      = S_DONE;
            end
            stli_pkg::MODE_LOAD: begin
              if (count_r == stli_pkg::CNT_W'(stli_pkg::TABLE_DEPTH)) begin
                res_status_nxt = stli_pkg::ST_FULL;
                state_nxt      = S_DONE;
              end else begin
                pos_nxt   = count_r;
                state_nxt = S_LD_RD;
              end
            end
            stli_pkg::MODE_QUERY: begin
              state_nxt = S_Q_RD;
            end
            default: begin
              res_status_nxt = stli_pkg::ST_RANGE;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_LD_RD: begin
        mem_req.raddr = stli_pkg::IDX_W'(pos_r - 1'b1);
        if (pos_r == '0) begin
          mem_req.we     = 1'b1;
          count_nxt      = count_r + 1'b1;
          res_status_nxt = stli_pkg::ST_LOADED;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_LD_CMP;
        end
      end
      S_LD_CMP: begin
        mem_req.we = 1'b1;
        if (rd_key > key_r) begin
          mem_req.wkey = rd_key;
          mem_req.wval = rd_val;
          pos_nxt      = pos_r - 1'b1;
          state_nxt    = S_LD_RD;
        end else begin
          count_nxt      = count_r + 1'b1;
          res_status_nxt = stli_pkg::ST_LOADED;
          state_nxt      = S_DONE;
        end
      end
      S_Q_RD: begin
        if (pos_r == count_r) begin
          res_status_nxt = stli_pkg::ST_RANGE;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_Q_CMP;
        end
      end
      S_Q_CMP: begin
        priority if (rd_key == key_r) begin
          res_value_nxt  = rd_val;
          res_status_nxt = stli_pkg::ST_EXACT;
          state_nxt      = S_DONE;
        end else if (rd_key > key_r) begin
          if (pos_r == '0) begin
            res_status_nxt = stli_pkg::ST_RANGE;
            state_nxt      = S_DONE;
          end else begin
            diff_k_nxt = {key_r[stli_pkg::KEY_W-1], key_r}
                       - {prev_key_r[stli_pkg::KEY_W-1], prev_key_r};
            diff_f_nxt = {rd_val[stli_pkg::VAL_W-1], rd_val}
                       - {prev_val_r[stli_pkg::VAL_W-1], prev_val_r};
            den_nxt    = den_wide[stli_pkg::DEN_W-1:0];
            state_nxt  = S_MUL;
          end
        end else begin
          prev_key_nxt = rd_key;
          prev_val_nxt = rd_val;
          pos_nxt      = pos_r + 1'b1;
          state_nxt    = S_Q_RD;
        end
      end
      S_MUL: begin
        prod_nxt  = diff_k_r * diff_f_r;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_req.start = 1'b1;
        neg_nxt       = prod_r[stli_pkg::PROD_W-1];
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          res_value_nxt  = sum_sat;
          res_status_nxt = stli_pkg::ST_INTERP;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          out_held_nxt   = stli_pkg::HELD_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      pos_r        <= pos_nxt;
      key_r        <= key_nxt;
      val_r        <= val_nxt;
      prev_key_r   <= prev_key_nxt;
      prev_val_r   <= prev_val_nxt;
      diff_k_r     <= diff_k_nxt;
      diff_f_r     <= diff_f_nxt;
      den_r        <= den_nxt;
      prod_r       <= prod_nxt;
      neg_r        <= neg_nxt;
      res_value_r  <= res_value_nxt;
      res_status_r <= res_status_nxt;
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
      out_held_r   <= out_held_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= stli_pkg::CNT_W'(stli_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV_WAIT))
    else $error("divider finished outside of its wait state");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_valid_r || out_rsp.ready)) |=>
      (out_valid_r && state_r == S_IDLE))
    else $error("finished request did not reach the output register");

  a_full_load_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req.mode == stli_pkg::MODE_LOAD
     && count_r == stli_pkg::CNT_W'(stli_pkg::TABLE_DEPTH)) |=> $stable(count_r))
    else $error("load into a full table changed the entry count");

endmodule

@@ test/sorted_table_linear_interpolation_core_test.sv @@
// Self-checking testbench for sorted_table_linear_interpolation_core: drives clear, load,
// query and spare-mode requests with random idling and back-pressure, checks every result
// in order. Depends on stli_pkg, stli_if and the core RTL.
`timescale 1ns / 100ps

module sorted_table_linear_interpolation_core_test;
  import stli_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 250;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] entry_value;
    bit                      drain;
  } table_req_t;

  typedef struct {
    logic signed [VAL_W-1:0] result_value;
    logic [STATUS_W-1:0]     status;
    logic [HELD_W-1:0]       entries_held;
  } table_rsp_t;

  logic clk = 1'b0;
  logic rst_n;

  stli_in_if  in_req ();
  stli_out_if out_rsp ();

  sorted_table_linear_interpolation_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp)
  );

  always #10 clk = ~clk;

  table_req_t pending [$];
  table_rsp_t rsp_q [$];
  logic signed [KEY_W-1:0] gen_keys [$];

  logic signed [KEY_W-1:0] tab_key [TABLE_DEPTH];
  logic signed [VAL_W-1:0] tab_val [TABLE_DEPTH];
  int tab_held = 0;

  int unsigned sent_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned rsp_seen = 0;
  int unsigned cyc = 0;
  int gap_left = 0;
  int hold_left = 0;
  int idle_cyc = 0;
  int err_cnt = 0;
  bit long_hold_done = 1'b0;
  wire calm = (cyc[9:8] == 2'b00);

  function automatic table_rsp_t table_apply(table_req_t r);
    table_rsp_t e;
    int pos;
    bit hit;
    longint a, c, fa, fc, acc;
    e.result_value = '0;
    e.status = ST_RANGE;
    case (r.mode)
      MODE_CLEAR: begin
        tab_held = 0;
        e.status = ST_CLEARED;
      end
      MODE_LOAD: begin
        if (tab_held >= TABLE_DEPTH) begin
          e.status = ST_FULL;
        end else begin
          pos = tab_held;
          while (pos > 0 && tab_key[pos-1] > r.key) begin
            tab_key[pos] = tab_key[pos-1];
            tab_val[pos] = tab_val[pos-1];
            pos--;
          end
          tab_key[pos] = r.key;
          tab_val[pos] = r.entry_value;
          tab_held++;
          e.status = ST_LOADED;
        end
      end
      MODE_QUERY: begin
        hit = 1'b0;
        for (int i = 0; i < tab_held && !hit; i++) begin
          if (tab_key[i] == r.key) begin
            hit = 1'b1;
            e.result_value = tab_val[i];
            e.status = ST_EXACT;
          end
        end
        for (int i = 1; i < tab_held && !hit; i++) begin
          a = tab_key[i-1];
          c = tab_key[i];
          if (longint'(r.key) > a && longint'(r.key) < c) begin
            hit = 1'b1;
            fa = tab_val[i-1];
            fc = tab_val[i];
            acc = fa + ((longint'(r.key) - a) * (fc - fa)) / (c - a);
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            e.result_value = acc[VAL_W-1:0];
            e.status = ST_INTERP;
          end
        end
      end
      default: e.status = ST_RANGE;
    endcase
    e.entries_held = HELD_W'(tab_held);
    return e;
  endfunction

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_req(logic [MODE_W-1:0] mode, logic signed [KEY_W-1:0] key,
                                    logic signed [VAL_W-1:0] value);
    table_req_t r;
    r.mode = mode;
    r.key = key;
    r.entry_value = value;
    r.drain = 1'b0;
    pending.push_back(r);
    if (mode == MODE_CLEAR) gen_keys.delete();
    else if (mode == MODE_LOAD && gen_keys.size() < TABLE_DEPTH) gen_keys.push_back(key);
  endfunction

  function automatic logic signed [KEY_W-1:0] load_key(bit wide);
    if (!wide) return KEY_W'($urandom_range(0, 80) - 40);
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return KEY_W'($urandom);
  endfunction

  function automatic logic signed [VAL_W-1:0] load_value();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 32'sh7fff_ffff;
    if (p == 1) return 32'sh8000_0000;
    if (p < 6) return VAL_W'($urandom_range(0, 2000) - 1000);
    return VAL_W'($urandom);
  endfunction

  function automatic logic signed [KEY_W-1:0] query_key(bit wide);
    int p;
    logic signed [KEY_W-1:0] k;
    p = $urandom_range(0, 9);
    if (gen_keys.size() == 0 || p >= 8) return wide ? KEY_W'($urandom) :
                                                      KEY_W'($urandom_range(0, 100) - 50);
    k = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
    if (p < 5) return k;
    return k + KEY_W'($urandom_range(0, 6) - 3);
  endfunction

  // accepted requests update the expected table
  always @(posedge clk) begin
    if (rst_n && in_req.valid && in_req.ready) begin
      table_req_t r;
      r.mode = in_req.mode;
      r.key = in_req.key;
      r.entry_value = in_req.entry_value;
      r.drain = 1'b0;
      taken_cnt <= taken_cnt + 1;
      rsp_q.push_back(table_apply(r));
    end
  end

  always @(negedge clk) begin
    table_req_t nxt;
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else if (sent_cnt != taken_cnt) begin
    end else if (gap_left > 0) begin
      in_req.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending.size() != 0 && !(pending[0].drain && rsp_q.size() != 0)) begin
      nxt = pending.pop_front();
      in_req.valid <= 1'b1;
      in_req.mode <= nxt.mode;
      in_req.key <= nxt.key;
      in_req.entry_value <= nxt.entry_value;
      sent_cnt <= sent_cnt + 1;
      gap_left <= calm ? 0 : idle_len();
    end else begin
      in_req.valid <= 1'b0;
    end
  end

  // result monitor
  always @(negedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else if (!long_hold_done && rsp_seen == 400) begin
      long_hold_done <= 1'b1;
      hold_left <= 800;
      out_rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_rsp.ready <= 1'b0;
    end else if (calm || $urandom_range(0, 3) != 0) begin
      out_rsp.ready <= 1'b1;
    end else begin
      out_rsp.ready <= 1'b0;
      hold_left <= idle_len();
    end
  end

  always @(posedge clk) begin
    table_rsp_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      rsp_seen <= rsp_seen + 1;
      if (rsp_q.size() == 0) begin
        $display("%0t: unexpected result, status %0d value %0d held %0d", $time,
                 out_rsp.status, out_rsp.result_value, out_rsp.entries_held);
        err_cnt++;
      end else begin
        want = rsp_q.pop_front();
        if (out_rsp.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_rsp.status);
          err_cnt++;
        end
        if (out_rsp.result_value !== want.result_value) begin
          $display("%0t: result_value expected %0d got %0d", $time, want.result_value,
                   out_rsp.result_value);
          err_cnt++;
        end
        if (out_rsp.entries_held !== want.entries_held) begin
          $display("%0t: entries_held expected %0d got %0d", $time, want.entries_held,
                   out_rsp.entries_held);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IDLE_LIMIT) begin
      $display("%0t: no request or result accepted for %0d cycles", $time, idle_cyc);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    bit wide;
    int n_load;
    int n_query;
    in_req.valid = 1'b0;
    in_req.mode = MODE_CLEAR;
    in_req.key = '0;
    in_req.entry_value = '0;
    out_rsp.ready = 1'b0;
    rst_n = 1'b0;

    queue_req(MODE_QUERY, 16'sh0000, 32'sh0000_0000);
    queue_req(MODE_SPARE, 16'sh7fff, 32'sh7fff_ffff);
    queue_req(MODE_LOAD,  16'sh8000, 32'sh8000_0000);
    queue_req(MODE_QUERY, 16'sh8000, 32'sh0000_0000);
    queue_req(MODE_QUERY, 16'sh0000, 32'shffff_ffff);
    queue_req(MODE_LOAD,  16'sh7fff, 32'sh7fff_ffff);
    queue_req(MODE_QUERY, 16'sh0000, 32'sh0000_0000);
    queue_req(MODE_QUERY, 16'sh8001, 32'sh0000_0000);
    queue_req(MODE_QUERY, 16'sh7ffe, 32'sh0000_0000);
    queue_req(MODE_LOAD,  16'sh0000, 32'sd5);
    queue_req(MODE_LOAD,  16'sh0000, 32'sd7);
    queue_req(MODE_QUERY, 16'sh0000, 32'sh0000_0000);
    queue_req(MODE_LOAD,  16'sh0100, -32'sd1000);
    queue_req(MODE_QUERY, 16'sh0080, 32'sh0000_0000);
    queue_req(MODE_QUERY, 16'sh0001, 32'sh0000_0000);
    queue_req(MODE_QUERY, 16'sh7fff, 32'sh0000_0000);
    queue_req(MODE_SPARE, 16'sh0000, 32'sh0000_0000);
    queue_req(MODE_CLEAR, 16'shffff, 32'shffff_ffff);
    pending[pending.size()-1].drain = 1'b1;
    queue_req(MODE_QUERY, 16'sh0000, 32'sh0000_0000);
    queue_req(MODE_LOAD,  16'sh000a, 32'sd100);
    queue_req(MODE_QUERY, 16'sh0005, 32'sh0000_0000);
    queue_req(MODE_QUERY, 16'sh0014, 32'sh0000_0000);
    queue_req(MODE_LOAD,  16'sh000a, 32'sd200);
    queue_req(MODE_QUERY, 16'sh000a, 32'sh0000_0000);

    while (pending.size() < RANDOM_ITEMS + 24) begin
      if ($urandom_range(0, 2) == 0) queue_req(MODE_CLEAR, KEY_W'($urandom), VAL_W'($urandom));
      wide = $urandom_range(0, 1);
      n_load = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
      repeat (n_load) queue_req(MODE_LOAD, load_key(wide), load_value());
      n_query = $urandom_range(4, 16);
      repeat (n_query) queue_req(($urandom_range(0, 15) == 0) ? MODE_SPARE : MODE_QUERY,
                                 query_key(wide), VAL_W'($urandom));
    end
    pending[900].drain = 1'b1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || sent_cnt != taken_cnt || rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && rsp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/stli_pkg.sv
rtl/stli_if.sv
rtl/stli_table.sv
rtl/stli_div.sv
rtl/sorted_table_linear_interpolation_core.sv
test/sorted_table_linear_interpolation_core_test.sv
